/* rtl/mmc_pkg.sv */
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants of the masked median composite
// Word layouts of the sample, result and configuration channels, register
// indexes and the controller state encoding.
// ----------------------------------------------------------------------------
package mmc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgNullValue = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinValid  = 2'd1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      clear;
    logic                      last_band;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] median;
    logic [CountW-1:0]         valid_count;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_word_t;

  // broadcast control to every cell of the sorted chain
  typedef struct packed {
    logic                      insert;
    logic                      shift;
    logic signed [SampleW-1:0] sample;
  } cell_ctrl_t;

  // what a cell hands to its right-hand neighbor
  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic                      gt;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

/* rtl/mmc_if.sv */
// ----------------------------------------------------------------------------
// mmc channel interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface mmc_in_if;
  logic              valid;
  logic              ready;
  mmc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmc_out_if;
  logic               valid;
  logic               ready;
  mmc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmc_cfg_if;
  logic               valid;
  logic               ready;
  mmc_pkg::cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mmc_cell.sv */
// ----------------------------------------------------------------------------
// mmc_cell: one slot of the sorted insertion chain
// Holds one kept sample. On insert it keeps its value, takes the left
// neighbor's value or takes the new sample; on shift it takes the right
// neighbor's value so the chain drains toward slot 0.
// ----------------------------------------------------------------------------
module mmc_cell (
  input  logic                              clk_i,
  input  mmc_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occ_i,
  input  mmc_pkg::cell_link_t               left_i,
  input  logic signed [mmc_pkg::SampleW-1:0] right_i,
  output mmc_pkg::cell_link_t               link_o
);

  logic signed [mmc_pkg::SampleW-1:0] value_q, value_d;
  logic                               gt;

  assign gt = occ_i && (value_q > ctrl_i.sample);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (!(occ_i && !gt)) begin
        value_d = left_i.gt ? left_i.value : ctrl_i.sample;
      end
    end else if (ctrl_i.shift) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value = value_q;
  assign link_o.gt    = gt;

endmodule

/* rtl/masked_median_composite_int16.sv */
// ----------------------------------------------------------------------------
// masked_median_composite_int16: per-pixel median of masked band samples
// Band words of one pixel stream in on in_i; kept samples are inserted into
// a chain of sorted cells, one word per cycle while the block is idle. The
// last-band word ends the pixel and a result word leaves on out_o.
//
// Usage:
//  - cfg_i (always ready) writes null_value (index 0) and min_valid (index 1);
//    the user writes them only while idle (not enforced); other indexes ignored.
//  - A non-last band word is taken every cycle while the block is idle.
//  - After a last-band word with n kept samples the chain shifts toward
//    slot 0 until the lower middle sample is in slot 0 (no shift when n
//    is 0), then the median is formed from slots 0 and 1 into the output
//    register; in_i is not ready during that drain.
//  - The output register lets the next pixel's bands enter while a result
//    waits; if out_o stalls, the drain holds at its end until it is free.
//  - Reset empties the chain, clears the output and sets null_value to 0
//    and min_valid to 1.
// ----------------------------------------------------------------------------
module masked_median_composite_int16 #(
  parameter int unsigned MAX_BANDS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmc_in_if.sink     in_i,
  mmc_out_if.source  out_o,
  mmc_cfg_if.sink    cfg_i
);

  localparam int unsigned CntW = $clog2(MAX_BANDS + 1);

  // configuration
  logic signed [mmc_pkg::SampleW-1:0] null_value_q;
  logic [mmc_pkg::CountW-1:0]         min_valid_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      null_value_q <= '0;
      min_valid_q  <= mmc_pkg::CountW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        mmc_pkg::CfgNullValue: null_value_q <= cfg_i.data.data;
        mmc_pkg::CfgMinValid:  min_valid_q  <= cfg_i.data.data[mmc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // control
  mmc_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] drain_q, drain_d;
  logic            out_valid_q, out_valid_d;
  mmc_pkg::out_word_t out_q, out_d;

  logic            accept, keep, ins;
  logic [CntW-1:0] n_new;
  logic            out_free;
  mmc_pkg::out_word_t result;

  mmc_pkg::cell_ctrl_t                ctrl;
  mmc_pkg::cell_link_t                link [MAX_BANDS+1];
  logic signed [mmc_pkg::SampleW-1:0] val_ext [MAX_BANDS+1];

  assign in_i.ready = (state_q == mmc_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign keep       = in_i.data.clear && (in_i.data.sample != null_value_q);
  assign ins        = accept && keep && (count_q < CntW'(MAX_BANDS));
  assign n_new      = count_q + CntW'(ins);
  assign out_free   = !out_valid_q || out_o.ready;

  assign ctrl.insert = ins;
  assign ctrl.shift  = (state_q == mmc_pkg::ST_DRAIN) && (drain_q != '0);
  assign ctrl.sample = in_i.data.sample;

  // sorted cell chain
  assign link[0].value = '0;
  assign link[0].gt    = 1'b0;

  for (genvar i = 0; i < MAX_BANDS; i++) begin : g_cell
    mmc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .occ_i   (count_q > CntW'(i)),
      .left_i  (link[i]),
      .right_i (val_ext[i+1]),
      .link_o  (link[i+1])
    );
    assign val_ext[i] = link[i+1].value;
  end
  assign val_ext[MAX_BANDS] = link[MAX_BANDS].value;

  // median from the two lowest slots after draining
  logic signed [mmc_pkg::SampleW:0] pair_sum, pair_adj;
  logic [mmc_pkg::CountW-1:0]       n_ext;

  assign n_ext    = mmc_pkg::CountW'(n_q);
  assign pair_sum = {val_ext[0][mmc_pkg::SampleW-1], val_ext[0]} +
                    {val_ext[1][mmc_pkg::SampleW-1], val_ext[1]};
  // round toward zero: bias negative sums by one before halving
  assign pair_adj = pair_sum + (mmc_pkg::SampleW+1)'(pair_sum[mmc_pkg::SampleW]);

  always_comb begin
    result.valid_count = n_ext;
    if (n_q == '0 || n_ext < min_valid_q) begin
      result.median = null_value_q;
    end else if (n_q[0]) begin
      result.median = val_ext[0];
    end else begin
      result.median = pair_adj[mmc_pkg::SampleW:1];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      mmc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.data.last_band) begin
            count_d = '0;
            n_d     = n_new;
            drain_d = (n_new == '0) ? '0 : ((n_new - CntW'(1)) >> 1);
            state_d = mmc_pkg::ST_DRAIN;
          end else begin
            count_d = n_new;
          end
        end
      end
      mmc_pkg::ST_DRAIN: begin
        if (drain_q != '0) begin
          drain_d = drain_q - CntW'(1);
        end else if (out_free) begin
          out_d       = result;
          out_valid_d = 1'b1;
          state_d     = mmc_pkg::ST_IDLE;
        end
      end
      default: state_d = mmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmc_pkg::ST_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
